// ----- rtl/rkc_pkg.sv -----
// Shared types and constants of the RGB kernel convolution filter.
package rkc_pkg;

   localparam int CHAN_W  = 8;
   localparam int PIX_W   = 3 * CHAN_W;
   localparam int COEF_W  = 12;
   localparam int PROD_W  = CHAN_W + 1 + COEF_W;
   localparam int CSR_W   = 60;
   localparam int CSR_IDX_W = 3;
   localparam int KROWS   = 5;
   localparam int KROW_IDX_W = 3;
   localparam int WIDTH_W = 12;
   localparam int HEIGHT_W = 13;
   localparam int DIVISOR_W = 16;
   localparam int LIN_W   = WIDTH_W + HEIGHT_W;
   localparam int POS_W   = 15;
   localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DIVISOR      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_ROW_0 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_ROW_1 = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_ROW_2 = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_ROW_3 = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_ROW_4 = 3'd7;

   localparam logic ACTION_PIXEL = 1'b0;

   typedef struct packed {
      logic              action;
      logic [CHAN_W-1:0] in_red;
      logic [CHAN_W-1:0] in_green;
      logic [CHAN_W-1:0] in_blue;
   } req_type;

   typedef struct packed {
      logic [CHAN_W-1:0] out_red;
      logic [CHAN_W-1:0] out_green;
      logic [CHAN_W-1:0] out_blue;
      logic              frame_last;
   } rsp_type;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_CHECK = 7'b0000010,
      S_SCAN  = 7'b0000100,
      S_DRAIN = 7'b0001000,
      S_PREP  = 7'b0010000,
      S_DIV   = 7'b0100000,
      S_WAIT  = 7'b1000000
   } state_type;

   typedef struct packed {
      logic take;
      logic scan_start;
      logic scan_step;
      logic div_start;
      logic div_step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic emit;
      logic scan_last;
      logic div_done;
      logic rsp_free;
   } status_type;

endpackage

// ----- rtl/rkc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module rkc_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 4101
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [0:DEPTH-1];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/rkc_ctrl.sv -----
// Sequencing state machine of the convolution filter.
module rkc_ctrl import rkc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type st,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (st.emit) begin
               cmd.scan_start = 1'b1;
               state_in       = S_SCAN;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (st.scan_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_PREP;
         end
         S_PREP: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV;
         end
         S_DIV: begin
            if (st.div_done) begin
               state_in = S_WAIT;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         S_WAIT: begin
            if (st.rsp_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- rtl/rkc_dpath.sv -----
// Datapath of the convolution filter: registers, counters, line store, MAC and divider.
module rkc_dpath import rkc_pkg::*; #(
   parameter int KERNEL_SIZE = 3,
   parameter int MAX_WIDTH   = 2048
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata,
   input  req_type              req_data,
   input  logic                 rsp_stall,
   input  cmd_type              cmd,
   output status_type           st,
   output logic                 rsp_valid,
   output rsp_type              rsp_data
);

   localparam int PAD    = KERNEL_SIZE / 2;
   localparam int TAPS   = 2 * PAD + 1;
   localparam int DEPTH  = 2 * PAD * MAX_WIDTH + TAPS;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int AS_W   = ADDR_W + 2;
   localparam int TAP_W  = (TAPS > 1) ? $clog2(TAPS) : 1;
   localparam int ACC_W  = PROD_W + $clog2(TAPS * TAPS);
   localparam int DIV_W  = ACC_W - 1;
   localparam int DCNT_W = $clog2(DIV_W + 1);
   localparam logic signed [AS_W-1:0] DEPTH_S = AS_W'(DEPTH);
   localparam logic [TAP_W-1:0] TAP_LAST = TAP_W'(TAPS - 1);

   // Configuration registers.
   logic [WIDTH_W-1:0]   width_ff;
   logic [HEIGHT_W-1:0]  height_ff;
   logic [DIVISOR_W-1:0] divisor_ff;
   logic [CSR_W-1:0]     kernel_ff [0:KROWS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= 12'd640;
         height_ff    <= 13'd480;
         divisor_ff   <= 16'd1;
         kernel_ff[0] <= '0;
         kernel_ff[1] <= CSR_W'(4096);
         kernel_ff[2] <= '0;
         kernel_ff[3] <= '0;
         kernel_ff[4] <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  width_ff     <= csr_wdata[WIDTH_W-1:0];
            CSR_IMAGE_HEIGHT: height_ff    <= csr_wdata[HEIGHT_W-1:0];
            CSR_DIVISOR:      divisor_ff   <= csr_wdata[DIVISOR_W-1:0];
            CSR_KERNEL_ROW_0: kernel_ff[0] <= csr_wdata;
            CSR_KERNEL_ROW_1: kernel_ff[1] <= csr_wdata;
            CSR_KERNEL_ROW_2: kernel_ff[2] <= csr_wdata;
            CSR_KERNEL_ROW_3: kernel_ff[3] <= csr_wdata;
            CSR_KERNEL_ROW_4: kernel_ff[4] <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic [WIDTH_W-1:0]   w_eff;
   logic [HEIGHT_W-1:0]  h_eff;
   logic [DIVISOR_W-1:0] d_eff;

   always_comb begin
      if (width_ff == '0) begin
         w_eff = WIDTH_W'(1);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         w_eff = WIDTH_W'(MAX_WIDTH);
      end else begin
         w_eff = width_ff;
      end
      h_eff = (height_ff == '0) ? HEIGHT_W'(1) : height_ff;
      d_eff = (divisor_ff == '0) ? DIVISOR_W'(1) : divisor_ff;
   end

   // Frame size and look-ahead, registered off the multiplier.
   logic [LIN_W-1:0] total_ff, padw_ff;

   always_ff @(posedge clock) begin
      total_ff <= LIN_W'(w_eff * h_eff);
      padw_ff  <= LIN_W'(PAD * w_eff + PAD);
   end

   // Frame position counters.
   logic [HEIGHT_W-1:0] in_row_ff, in_row_in, out_row_ff, out_row_in;
   logic [WIDTH_W-1:0]  in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [LIN_W-1:0]    in_lin_ff, in_lin_in, out_lin_ff, out_lin_in;
   logic [ADDR_W-1:0]   in_pos_ff, in_pos_in, out_pos_ff, out_pos_in;
   logic                in_active, frame_end;
   logic [LIN_W:0]      need, need_cap;

   function automatic logic [ADDR_W-1:0] wrap_pos(input logic signed [AS_W-1:0] v);
      logic signed [AS_W-1:0] r;
      if (v < 0) begin
         r = v + DEPTH_S;
      end else if (v >= DEPTH_S) begin
         r = v - DEPTH_S;
      end else begin
         r = v;
      end
      return r[ADDR_W-1:0];
   endfunction

   assign in_active = in_row_ff < h_eff;
   assign need      = {1'b0, out_lin_ff} + {1'b0, padw_ff} + (LIN_W+1)'(1);
   assign need_cap  = (need > {1'b0, total_ff}) ? {1'b0, total_ff} : need;
   assign st.emit   = (out_row_ff < h_eff) &&
                      (!in_active || ({1'b0, in_lin_ff} >= need_cap));

   always_comb begin
      in_row_in  = in_row_ff;
      in_col_in  = in_col_ff;
      in_lin_in  = in_lin_ff;
      in_pos_in  = in_pos_ff;
      out_row_in = out_row_ff;
      out_col_in = out_col_ff;
      out_lin_in = out_lin_ff;
      out_pos_in = out_pos_ff;
      frame_end  = 1'b0;
      if (cmd.take && in_active) begin
         if (13'(in_col_ff) + 13'd1 >= 13'(w_eff)) begin
            in_col_in = '0;
            in_row_in = in_row_ff + HEIGHT_W'(1);
         end else begin
            in_col_in = in_col_ff + WIDTH_W'(1);
         end
         in_lin_in = in_lin_ff + LIN_W'(1);
         in_pos_in = wrap_pos(AS_W'(in_pos_ff) + AS_W'(1));
      end
      if (cmd.finish) begin
         if (13'(out_col_ff) + 13'd1 >= 13'(w_eff)) begin
            out_col_in = '0;
            out_row_in = out_row_ff + HEIGHT_W'(1);
         end else begin
            out_col_in = out_col_ff + WIDTH_W'(1);
         end
         out_lin_in = out_lin_ff + LIN_W'(1);
         out_pos_in = wrap_pos(AS_W'(out_pos_ff) + AS_W'(1));
         if (out_row_in >= h_eff) begin
            frame_end  = 1'b1;
            in_row_in  = '0;
            in_col_in  = '0;
            in_lin_in  = '0;
            in_pos_in  = '0;
            out_row_in = '0;
            out_col_in = '0;
            out_lin_in = '0;
            out_pos_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_row_ff  <= '0;
         in_col_ff  <= '0;
         in_lin_ff  <= '0;
         in_pos_ff  <= '0;
         out_row_ff <= '0;
         out_col_ff <= '0;
         out_lin_ff <= '0;
         out_pos_ff <= '0;
      end else begin
         in_row_ff  <= in_row_in;
         in_col_ff  <= in_col_in;
         in_lin_ff  <= in_lin_in;
         in_pos_ff  <= in_pos_in;
         out_row_ff <= out_row_in;
         out_col_ff <= out_col_in;
         out_lin_ff <= out_lin_in;
         out_pos_ff <= out_pos_in;
      end
   end

   // Line store.
   logic [PIX_W-1:0] wr_pix, rd_pix;
   logic [ADDR_W-1:0] addr_ff, addr_in;

   assign wr_pix = (req_data.action == ACTION_PIXEL) ?
                   {req_data.in_blue, req_data.in_green, req_data.in_red} : '0;

   rkc_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (cmd.take && in_active),
      .wr_addr (in_pos_ff),
      .wr_data (wr_pix),
      .rd_en   (cmd.scan_step),
      .rd_addr (addr_ff),
      .rd_data (rd_pix)
   );

   // Window scan.
   logic [TAP_W-1:0]         ki_ff, ki_in, kj_ff, kj_in;
   logic signed [POS_W-1:0]  rr_ff, rr_in, cc_ff, cc_in, cc_first;
   logic [CSR_W-1:0]         row_sel;
   logic signed [COEF_W-1:0] coef, coef_ff;
   logic                     tap_ok, tap_ok_ff, pipe_ff;

   assign cc_first = $signed(POS_W'(out_col_ff)) - POS_W'(PAD);
   assign row_sel  = kernel_ff[KROW_IDX_W'(ki_ff)];
   assign coef     = $signed(row_sel[COEF_W * KROW_IDX_W'(kj_ff) +: COEF_W]);
   assign tap_ok   = !rr_ff[POS_W-1] && !cc_ff[POS_W-1] &&
                     ($unsigned(rr_ff) < POS_W'(h_eff)) &&
                     ($unsigned(cc_ff) < POS_W'(w_eff));
   assign st.scan_last = (ki_ff == TAP_LAST) && (kj_ff == TAP_LAST);

   always_comb begin
      ki_in   = ki_ff;
      kj_in   = kj_ff;
      rr_in   = rr_ff;
      cc_in   = cc_ff;
      addr_in = addr_ff;
      if (cmd.scan_start) begin
         ki_in   = '0;
         kj_in   = '0;
         rr_in   = $signed(POS_W'(out_row_ff)) - POS_W'(PAD);
         cc_in   = cc_first;
         addr_in = wrap_pos(AS_W'(out_pos_ff) - AS_W'(padw_ff));
      end else if (cmd.scan_step) begin
         if (kj_ff == TAP_LAST) begin
            kj_in   = '0;
            ki_in   = ki_ff + TAP_W'(1);
            rr_in   = rr_ff + POS_W'(1);
            cc_in   = cc_first;
            addr_in = wrap_pos(AS_W'(addr_ff) + AS_W'(w_eff) - AS_W'(2 * PAD));
         end else begin
            kj_in   = kj_ff + TAP_W'(1);
            cc_in   = cc_ff + POS_W'(1);
            addr_in = wrap_pos(AS_W'(addr_ff) + AS_W'(1));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ki_ff   <= '0;
         kj_ff   <= '0;
         pipe_ff <= 1'b0;
      end else begin
         ki_ff   <= ki_in;
         kj_ff   <= kj_in;
         pipe_ff <= cmd.scan_step;
      end
      rr_ff     <= rr_in;
      cc_ff     <= cc_in;
      addr_ff   <= addr_in;
      tap_ok_ff <= tap_ok;
      coef_ff   <= coef;
   end

   // Multiply-accumulate, divide and clamp, one lane per colour channel.
   logic signed [ACC_W-1:0] acc_ff [0:2];
   logic signed [ACC_W-1:0] acc_in [0:2];
   logic [DIV_W-1:0]        q_ff [0:2];
   logic [DIV_W-1:0]        q_in [0:2];
   logic [DIVISOR_W:0]      r_ff [0:2];
   logic [DIVISOR_W:0]      r_in [0:2];
   logic                    neg_ff [0:2];
   logic [CHAN_W-1:0]       chan_out [0:2];
   logic [DCNT_W-1:0]       dcnt_ff, dcnt_in;

   always_comb begin
      logic signed [PROD_W-1:0] prod;
      logic [DIVISOR_W:0]       t;
      logic                     ge;
      for (int c = 0; c < 3; c++) begin
         prod = $signed({1'b0, rd_pix[CHAN_W*c +: CHAN_W]}) * coef_ff;
         acc_in[c] = acc_ff[c];
         if (cmd.scan_start) begin
            acc_in[c] = '0;
         end else if (pipe_ff && tap_ok_ff) begin
            acc_in[c] = acc_ff[c] + ACC_W'(prod);
         end
         t  = {r_ff[c][DIVISOR_W-1:0], q_ff[c][DIV_W-1]};
         ge = t >= {1'b0, d_eff};
         q_in[c] = q_ff[c];
         r_in[c] = r_ff[c];
         if (cmd.div_start) begin
            q_in[c] = acc_ff[c][DIV_W-1:0];
            r_in[c] = '0;
         end else if (cmd.div_step) begin
            q_in[c] = {q_ff[c][DIV_W-2:0], ge};
            r_in[c] = ge ? (t - {1'b0, d_eff}) : t;
         end
         if (neg_ff[c]) begin
            chan_out[c] = '0;
         end else if (q_ff[c] > DIV_W'(CHAN_MAX)) begin
            chan_out[c] = CHAN_MAX;
         end else begin
            chan_out[c] = q_ff[c][CHAN_W-1:0];
         end
      end
      dcnt_in = dcnt_ff;
      if (cmd.div_start) begin
         dcnt_in = '0;
      end else if (cmd.div_step) begin
         dcnt_in = dcnt_ff + DCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < 3; c++) begin
         acc_ff[c] <= acc_in[c];
         q_ff[c]   <= q_in[c];
         r_ff[c]   <= r_in[c];
         if (cmd.div_start) begin
            neg_ff[c] <= acc_ff[c][ACC_W-1];
         end
      end
      if (reset) begin
         dcnt_ff <= '0;
      end else begin
         dcnt_ff <= dcnt_in;
      end
   end

   assign st.div_done = dcnt_ff == DCNT_W'(DIV_W);

   // Result register.
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   assign st.rsp_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.finish) begin
         rsp_data_ff <= '{out_red: chan_out[0], out_green: chan_out[1],
                          out_blue: chan_out[2], frame_last: frame_end};
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- rtl/rgb_kernel_convolution.sv -----
// Top level of the RGB kernel convolution filter.
// An input beat is taken in the idle state; the check state decides whether it releases a result;
// a beat that releases none returns straight to idle. One that releases a result passes the scan,
// drain, prep, divide and wait states; the line store's single read port stepping through the
// window and the one-bit-a-cycle divider set its cost; it then waits for a free result register.
// Reset is synchronous and active high; it restores the default registers and clears the counters.
// The line store needs no clearing pass: only positions of the current frame are ever read.
module rgb_kernel_convolution import rkc_pkg::*; #(
   parameter int KERNEL_SIZE = 3,
   parameter int MAX_WIDTH   = 2048
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   // The controller only sequences; every register of the filter but its state register sits in the datapath.
   cmd_type    cmd;
   status_type st;

   rkc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .st        (st),
      .cmd       (cmd)
   );

   // The datapath writes each beat of the frame's input into the line store, then sweeps the window
   // one tap a cycle, divides the three sums in parallel and parks the pixel in the result register,
   // so a new beat can be taken while the previous result still waits to be collected.
   rkc_dpath #(.KERNEL_SIZE(KERNEL_SIZE), .MAX_WIDTH(MAX_WIDTH)) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .st        (st),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- rtl/rkc_checker.sv -----
// Port-level assertions for the convolution filter and their binding.
module rkc_checker import rkc_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_decide_cycle: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken in the cycle after a beat");

   a_idle_ready: assert property (@(posedge clock) disable iff (reset)
      $past(reset) && !reset |-> !req_stall)
      else $error("not ready after reset");

endmodule

bind rgb_kernel_convolution rkc_checker u_rkc_checker (.*);
